/* sv/cdrsd_pkg.sv */
`timescale 1ns / 1ps
package cdrsd_pkg;

  localparam int unsigned USER_BYTES        = 2048;
  localparam int unsigned AUDIO_BYTES       = 2352;
  localparam int unsigned SYNC_BYTES        = 12;
  localparam int unsigned HEADER_BYTES      = 16;
  localparam int unsigned FRAMES_PER_MINUTE = 4500;
  localparam int unsigned FRAMES_PER_SECOND = 75;

  localparam logic [11:0] POS_MINUTE = 12'd12;
  localparam logic [11:0] POS_SECOND = 12'd13;
  localparam logic [11:0] POS_FRAME  = 12'd14;
  localparam logic [11:0] POS_MODE   = 12'd15;

  localparam logic [7:0] SYNC_EDGE    = 8'h00;
  localparam logic [7:0] SYNC_FILL    = 8'hFF;
  localparam logic [7:0] MINUTE_LIMIT = 8'hA0;
  localparam logic [7:0] SECOND_LIMIT = 8'h60;
  localparam logic [7:0] FRAME_LIMIT  = 8'h75;

  localparam logic [4:0] MODE1_START = 5'd16;
  localparam logic [4:0] MODE2_START = 5'd24;

  localparam logic [1:0] MODE_ZERO = 2'd0;
  localparam logic [1:0] MODE_ONE  = 2'd1;
  localparam logic [1:0] MODE_TWO  = 2'd2;

  typedef enum logic [1:0] {
    CFG_STORED_LEN   = 2'd0,
    CFG_DATA_OFFSET  = 2'd1,
    CFG_SYNC_PRESENT = 2'd2,
    CFG_AUDIO_MODE   = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [11:0] stored_len;
    logic [4:0]  default_data_offset;
    logic        sync_present;
    logic        audio_mode;
  } cfg_t;

  typedef struct packed {
    logic [11:0] byte_position;
    logic        sync_match;
    logic        bcd_ok;
    logic [18:0] minute_addr;
    logic [18:0] partial_addr;
    logic [18:0] frame_address;
    logic [1:0]  mode_bits;
    logic [4:0]  data_start;
  } state_t;

  typedef struct packed {
    logic [7:0]  user_byte;
    logic        last_of_sector;
    logic        header_valid;
    logic [18:0] sector_address;
    logic [1:0]  sector_mode;
  } result_t;

  function automatic logic bcd_below(input logic [7:0] v, input logic [7:0] limit);
    return (v[3:0] <= 4'd9) && (v[7:4] <= 4'd9) && (v < limit);
  endfunction

  function automatic logic [7:0] bcd_value(input logic [7:0] v);
    return 8'(({4'd0, v[7:4]} * 8'd10) + {4'd0, v[3:0]});
  endfunction

  function automatic logic [7:0] sync_byte(input logic [3:0] pos);
    return (pos == 4'd0 || pos == 4'd11) ? SYNC_EDGE : SYNC_FILL;
  endfunction

endpackage

/* sv/cdrsd_step.sv */
`timescale 1ns / 1ps
module cdrsd_step (
  input  cdrsd_pkg::cfg_t    cfg,
  input  cdrsd_pkg::state_t  st,
  input  logic [7:0]         image_byte,
  output cdrsd_pkg::state_t  st_next,
  output logic               emit,
  output cdrsd_pkg::result_t res
);
  import cdrsd_pkg::*;

  logic [11:0] pos;
  logic        sm;
  logic        bo;
  logic [4:0]  base_start;
  logic [4:0]  start;
  logic [11:0] start_w;
  logic [11:0] end_w;
  logic [12:0] pos_inc;
  logic        at_end;
  logic        synced;
  logic        hv;

  assign pos        = st.byte_position;
  assign base_start = (cfg.sync_present && cfg.default_data_offset < MODE1_START)
                      ? MODE1_START : cfg.default_data_offset;
  assign pos_inc    = {1'b0, pos} + 13'd1;
  assign at_end     = pos_inc >= {1'b0, cfg.stored_len};

  always_comb begin
    st_next = st;
    sm = (pos == '0) ? 1'b1 : st.sync_match;
    bo = (pos == '0) ? 1'b1 : st.bcd_ok;
    if (pos < 12'(SYNC_BYTES)) begin
      if (image_byte != sync_byte(pos[3:0])) sm = 1'b0;
    end else if (pos == POS_MINUTE) begin
      if (!bcd_below(image_byte, MINUTE_LIMIT)) bo = 1'b0;
      st_next.minute_addr = 19'(int'(bcd_value(image_byte)) * FRAMES_PER_MINUTE);
    end else if (pos == POS_SECOND) begin
      if (!bcd_below(image_byte, SECOND_LIMIT)) bo = 1'b0;
      st_next.partial_addr = 19'(st.minute_addr +
                             19'(int'(bcd_value(image_byte)) * FRAMES_PER_SECOND));
    end else if (pos == POS_FRAME) begin
      if (!bcd_below(image_byte, FRAME_LIMIT)) bo = 1'b0;
      st_next.frame_address = (bo && sm)
                              ? 19'(st.partial_addr + {11'd0, bcd_value(image_byte)})
                              : '0;
    end else if (pos == POS_MODE) begin
      st_next.mode_bits  = image_byte[1:0];
      st_next.data_start = base_start;
      if (cfg.sync_present && sm) begin
        if (image_byte[1:0] == MODE_ONE) st_next.data_start = MODE1_START;
        else if (image_byte[1:0] == MODE_TWO) st_next.data_start = MODE2_START;
      end
    end
    st_next.sync_match    = sm;
    st_next.bcd_ok        = bo;
    st_next.byte_position = at_end ? '0 : pos_inc[11:0];
  end

  assign synced  = cfg.sync_present && st_next.sync_match;
  assign start   = (pos < 12'(HEADER_BYTES)) ? base_start : st.data_start;
  assign start_w = {7'd0, start};
  assign end_w   = start_w + 12'(USER_BYTES);
  assign hv      = !cfg.audio_mode && synced && (pos >= POS_MODE) && st_next.bcd_ok;

  always_comb begin
    emit               = 1'b0;
    res.user_byte      = image_byte;
    res.last_of_sector = 1'b0;
    if (cfg.audio_mode) begin
      if (cfg.stored_len >= 12'(AUDIO_BYTES) && pos < 12'(AUDIO_BYTES)) begin
        emit               = 1'b1;
        res.last_of_sector = pos == 12'(AUDIO_BYTES - 1);
      end
    end else if (pos >= start_w && pos < end_w) begin
      emit               = 1'b1;
      res.last_of_sector = (pos == end_w - 12'd1) || at_end;
      if (pos >= 12'(HEADER_BYTES) && synced && st_next.mode_bits == MODE_ZERO) begin
        res.user_byte = '0;
      end
    end
    res.header_valid   = hv;
    res.sector_address = hv ? st.frame_address : '0;
    res.sector_mode    = (!cfg.audio_mode && synced && pos >= 12'(HEADER_BYTES))
                         ? st_next.mode_bits : MODE_ZERO;
  end

endmodule

/* sv/cd_raw_sector_deframer_unit.sv */
`timescale 1ns / 1ps
// Raw CD sector deframer. Takes one image byte per clock while in_ready is high
// and emits the user data (or audio) bytes of each stored sector with a
// last-of-sector mark, the BCD-checked header address and the sector mode.
// The sector walk, sync check and header decode are one short step from the
// state registers into a result register, so an item is accepted every cycle
// while in_ready is high and its result is registered there. The result
// register is backed by a one-item skid stage, so in_ready drops only when
// both hold an item that the sink has not taken. Configuration writes are taken
// at once (cfg_ready is always high) and must only be issued while the block is idle.
module cd_raw_sector_deframer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  image_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  user_byte,
  output logic        last_of_sector,
  output logic        header_valid,
  output logic [18:0] sector_address,
  output logic [1:0]  sector_mode
);
  import cdrsd_pkg::*;

  cfg_t    cfg;
  state_t  st;
  state_t  st_next;
  logic    emit;
  result_t res;
  result_t out_data;
  result_t skid_data;
  logic    skid_valid;
  logic    push;

  assign cfg_ready = 1'b1;
  assign in_ready  = !skid_valid;
  assign push      = in_valid && in_ready && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stored_len          <= 12'(AUDIO_BYTES);
      cfg.default_data_offset <= MODE1_START;
      cfg.sync_present        <= 1'b1;
      cfg.audio_mode          <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_STORED_LEN:   cfg.stored_len          <= cfg_data;
        CFG_DATA_OFFSET:  cfg.default_data_offset <= cfg_data[4:0];
        CFG_SYNC_PRESENT: cfg.sync_present        <= cfg_data[0];
        CFG_AUDIO_MODE:   cfg.audio_mode          <= cfg_data[0];
      endcase
    end
  end

  cdrsd_step u_step (
    .cfg        (cfg),
    .st         (st),
    .image_byte (image_byte),
    .st_next    (st_next),
    .emit       (emit),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st.byte_position <= '0;
      st.sync_match    <= 1'b1;
      st.bcd_ok        <= 1'b1;
      st.minute_addr   <= '0;
      st.partial_addr  <= '0;
      st.frame_address <= '0;
      st.mode_bits     <= MODE_ZERO;
      st.data_start    <= MODE1_START;
    end else if (in_valid && in_ready) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      if (skid_valid) out_data <= skid_data;
      else if (push) out_data <= res;
    end else if (push) begin
      skid_data <= res;
    end
  end

  assign user_byte      = out_data.user_byte;
  assign last_of_sector = out_data.last_of_sector;
  assign header_valid   = out_data.header_valid;
  assign sector_address = out_data.sector_address;
  assign sector_mode    = out_data.sector_mode;

endmodule
